// File: rtl/wfsn_pkg.sv
`default_nettype none
package wfsn_pkg;

	localparam int CHUNK_SIZE = 1024;
	localparam int BIN_COUNT  = 512;
	localparam int IDX_W      = $clog2(CHUNK_SIZE);
	localparam int BIN_W      = $clog2(BIN_COUNT);
	localparam int SMP_W      = 16;
	localparam int ENT_W      = 10;
	localparam int WIN_W      = 16;
	localparam int TW_W       = 17;
	localparam int X_W        = 32;
	localparam int PROD_W     = X_W + TW_W;
	localparam int ACC_W      = PROD_W + IDX_W;
	localparam int FRAC       = 30;
	localparam int RE_W       = ACC_W - FRAC;
	localparam int RAD_W      = 2 * RE_W;
	localparam int ROOT_W     = RE_W;
	localparam int REM_W      = ROOT_W + 2;
	localparam int RCNT_W     = $clog2(ROOT_W);
	localparam int MAG_W      = 27;
	localparam int DIV_W      = MAG_W + 1;
	localparam int Q_W        = 16;
	localparam int DCNT_W     = $clog2(Q_W);
	localparam int Q_DEPTH    = 4;
	localparam int QP_W       = $clog2(Q_DEPTH);

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'd536870912);

	localparam logic REG_FLOOR = 1'b0;
	localparam logic REG_CEIL  = 1'b1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		op_t                      opcode;
		logic signed [SMP_W-1:0]  sample;
		logic [ENT_W-1:0]         index;
	} cmd_t;

	typedef struct packed {
		logic             we;
		logic [BIN_W-1:0] addr;
		logic [MAG_W-1:0] data;
	} mag_wr_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] low;
		logic [MAG_W-1:0] high;
	} xf_stat_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_XFORM,
		B_FETCH,
		B_SDIV,
		B_SWAIT,
		B_MDIV,
		B_MWAIT,
		B_OUT
	} b_state_t;

	typedef enum logic [2:0] {
		X_IDLE,
		X_RUN,
		X_DRAIN,
		X_ROUND,
		X_SQUARE,
		X_ADD,
		X_ROOT,
		X_STORE
	} x_state_t;

	localparam longint ARC [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1};

	function automatic longint clamp_unit(input longint v);
		if (v > 32768) return 32768;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic logic [2*TW_W-1:0] cordic(input logic [31:0] phase);
		longint x;
		longint y;
		longint z;
		longint nx;
		logic [31:0] ph;
		logic flip;
		ph = phase;
		flip = 1'b0;
		x = 652032875;
		y = 0;
		if ((ph - 32'h4000_0000) < 32'h8000_0000) begin
			ph = ph - 32'h8000_0000;
			flip = 1'b1;
		end
		z = longint'({32'h0, ph});
		if (ph[31]) begin
			z = z - 64'sd4294967296;
		end
		for (int k = 0; k < 30; k++) begin
			if (z >= 0) begin
				nx = x - (y >>> k);
				y = y + (x >>> k);
				z = z - ARC[k];
			end else begin
				nx = x + (y >>> k);
				y = y - (x >>> k);
				z = z + ARC[k];
			end
			x = nx;
		end
		x = clamp_unit((x + 16384) >>> 15);
		y = clamp_unit((y + 16384) >>> 15);
		if (flip) begin
			x = -x;
			y = -y;
		end
		return {TW_W'(x), TW_W'(y)};
	endfunction

	typedef logic [WIN_W-1:0] win_tab_t [CHUNK_SIZE];
	typedef logic [2*TW_W-1:0] tw_tab_t [CHUNK_SIZE];

	function automatic win_tab_t build_window();
		win_tab_t t;
		logic [2*TW_W-1:0] cs;
		longint c;
		for (int i = 0; i < CHUNK_SIZE; i++) begin
			cs = cordic(32'((longint'(i) <<< 32) / (CHUNK_SIZE - 1)));
			c = longint'($signed(cs[2*TW_W-1:TW_W]));
			t[i] = WIN_W'((32769 - c) >>> 1);
		end
		return t;
	endfunction

	function automatic tw_tab_t build_twiddle();
		tw_tab_t t;
		for (int i = 0; i < CHUNK_SIZE; i++) begin
			t[i] = cordic(32'((longint'(i) <<< 32) / CHUNK_SIZE));
		end
		return t;
	endfunction

	localparam win_tab_t WIN_TAB = build_window();
	localparam tw_tab_t  TW_TAB  = build_twiddle();

endpackage
`default_nettype wire

// File: rtl/wfsn_front.sv
`default_nettype none
module wfsn_front import wfsn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  cmd_t in_cmd,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic pop
);

	logic [QP_W-1:0] wr_q;
	logic [QP_W-1:0] rd_q;
	logic [QP_W:0]   cnt_q;
	cmd_t            fifo_q [Q_DEPTH];
	logic            push;

	assign in_stall  = cnt_q == (QP_W+1)'(Q_DEPTH);
	assign push      = in_valid & ~in_stall;
	assign cmd_valid = cnt_q != '0;
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QP_W'(1);
			if (pop) rd_q <= rd_q + QP_W'(1);
			cnt_q <= cnt_q + (QP_W+1)'(push) - (QP_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_cmd;
	end

endmodule
`default_nettype wire

// File: rtl/wfsn_div.sv
`default_nettype none
module wfsn_div import wfsn_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DIV_W-1:0] num,
	input  logic signed [DIV_W-1:0] den,
	output logic                    done,
	output logic [Q_W-1:0]          quo
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIV_W:0]    rem_q;
	logic [DIV_W:0]    dvs_q;
	logic [Q_W-1:0]    quo_q;
	logic signed [DIV_W-1:0] den_e;
	logic [DIV_W:0]    a_abs;
	logic [DIV_W:0]    b_abs;
	logic [DIV_W:0]    rem_sh;
	logic              zero_res;

	always_comb begin
		den_e    = (den == '0) ? DIV_W'(1) : den;
		a_abs    = num[DIV_W-1] ? (DIV_W+1)'(-num) : (DIV_W+1)'(num);
		b_abs    = den_e[DIV_W-1] ? (DIV_W+1)'(-den_e) : (DIV_W+1)'(den_e);
		a_abs[DIV_W] = 1'b0;
		b_abs[DIV_W] = 1'b0;
		if (num[DIV_W-1] ^ den_e[DIV_W-1]) begin
			a_abs[DIV_W] = 1'b0;
		end
		zero_res = (num == '0) || (num[DIV_W-1] != den_e[DIV_W-1]);
		rem_sh   = {rem_q[DIV_W-1:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (zero_res || a_abs >= b_abs) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= a_abs;
			dvs_q <= b_abs;
			if (zero_res) quo_q <= '0;
			else quo_q <= '1;
		end else if (busy_q) begin
			if (rem_sh >= dvs_q) begin
				rem_q <= rem_sh - dvs_q;
				quo_q <= {quo_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[Q_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// File: rtl/wfsn_xform.sv
`default_nettype none
module wfsn_xform import wfsn_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic [IDX_W-1:0]        samp_addr,
	input  logic signed [SMP_W-1:0] samp_rd,
	output mag_wr_t                 mag_wr,
	output xf_stat_t                stat
);

	x_state_t state_q;
	x_state_t state_d;

	logic [IDX_W-1:0]  n_q;
	logic [IDX_W-1:0]  t_q;
	logic [BIN_W-1:0]  k_q;
	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic [WIN_W-1:0]  win_s1;
	logic signed [TW_W-1:0] cos_s1;
	logic signed [TW_W-1:0] sin_s1;
	logic signed [X_W-1:0]  x_s2;
	logic signed [TW_W-1:0] cos_s2;
	logic signed [TW_W-1:0] sin_s2;
	logic signed [PROD_W-1:0] pre_s3;
	logic signed [PROD_W-1:0] pim_s3;
	logic signed [ACC_W-1:0]  acc_re_q;
	logic signed [ACC_W-1:0]  acc_im_q;
	logic signed [RE_W-1:0]   re_q;
	logic signed [RE_W-1:0]   im_q;
	logic [RAD_W-1:0]  sqr_q;
	logic [RAD_W-1:0]  sqi_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [RCNT_W-1:0] rcnt_q;
	logic [MAG_W-1:0]  low_q;
	logic [MAG_W-1:0]  high_q;

	logic issue;
	logic last_n;
	logic drained;
	logic root_end;
	logic last_k;
	logic signed [X_W:0]        prod_x;
	logic signed [PROD_W-1:0]   prod_re;
	logic signed [PROD_W-1:0]   prod_im;
	logic signed [ACC_W-1:0]    re_rnd;
	logic signed [ACC_W-1:0]    im_rnd;
	logic signed [RAD_W-1:0]    sq_re;
	logic signed [RAD_W-1:0]    sq_im;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic [MAG_W-1:0]  mag;

	assign last_n   = n_q == IDX_W'(CHUNK_SIZE - 1);
	assign drained  = ~v_s1 & ~v_s2 & ~v_s3;
	assign root_end = rcnt_q == RCNT_W'(ROOT_W - 1);
	assign last_k   = k_q == BIN_W'(BIN_COUNT - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			X_IDLE:   if (start) state_d = X_RUN;
			X_RUN:    if (last_n) state_d = X_DRAIN;
			X_DRAIN:  if (drained) state_d = X_ROUND;
			X_ROUND:  state_d = X_SQUARE;
			X_SQUARE: state_d = X_ADD;
			X_ADD:    state_d = X_ROOT;
			X_ROOT:   if (root_end) state_d = X_STORE;
			X_STORE:  state_d = last_k ? X_IDLE : X_RUN;
			default:  state_d = X_IDLE;
		endcase
	end

	always_comb begin
		issue       = state_q == X_RUN;
		mag         = (root_q > ROOT_W'(MAG_MAX)) ? MAG_MAX : root_q[MAG_W-1:0];
		mag_wr.we   = state_q == X_STORE;
		mag_wr.addr = k_q;
		mag_wr.data = mag;
		stat.done   = (state_q == X_STORE) & last_k;
		stat.low    = low_q;
		stat.high   = high_q;
	end

	assign samp_addr = n_q;
	assign prod_x    = samp_rd * $signed({1'b0, win_s1});
	assign prod_re   = x_s2 * cos_s2;
	assign prod_im   = x_s2 * sin_s2;
	assign re_rnd    = (acc_re_q + ACC_HALF) >>> FRAC;
	assign im_rnd    = (acc_im_q + ACC_HALF) >>> FRAC;
	assign sq_re     = re_q * re_q;
	assign sq_im     = im_q * im_q;
	assign rem_sh    = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial     = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= X_IDLE;
			n_q     <= '0;
			t_q     <= '0;
			k_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			rcnt_q  <= '0;
			low_q   <= '0;
			high_q  <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			if (start) begin
				k_q <= '0;
				n_q <= '0;
				t_q <= '0;
			end else if (issue) begin
				n_q <= n_q + IDX_W'(1);
				t_q <= t_q + IDX_W'(k_q);
			end else if (state_q == X_STORE) begin
				k_q <= k_q + BIN_W'(1);
				n_q <= '0;
				t_q <= '0;
				if (k_q == '0 || mag < low_q) low_q <= mag;
				if (k_q == '0 || mag > high_q) high_q <= mag;
			end
			if (state_q == X_ADD) rcnt_q <= '0;
			else if (state_q == X_ROOT) rcnt_q <= rcnt_q + RCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		win_s1 <= WIN_TAB[n_q];
		{cos_s1, sin_s1} <= TW_TAB[t_q];
		x_s2   <= prod_x[X_W-1:0];
		cos_s2 <= cos_s1;
		sin_s2 <= sin_s1;
		pre_s3 <= prod_re;
		pim_s3 <= prod_im;
		if (start || state_q == X_STORE) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s3) begin
			acc_re_q <= acc_re_q + ACC_W'(pre_s3);
			acc_im_q <= acc_im_q - ACC_W'(pim_s3);
		end
		if (state_q == X_ROUND) begin
			re_q <= re_rnd[RE_W-1:0];
			im_q <= im_rnd[RE_W-1:0];
		end
		if (state_q == X_SQUARE) begin
			sqr_q <= sq_re;
			sqi_q <= sq_im;
		end
		if (state_q == X_ADD) begin
			rad_q  <= sqr_q + sqi_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == X_ROOT) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/wfsn_back.sv
`default_nettype none
module wfsn_back import wfsn_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	input  cmd_t                    cmd,
	output logic                    pop,
	input  logic                    cfg_valid,
	input  logic                    cfg_index,
	input  logic [SMP_W-1:0]        cfg_data,
	output logic                    xf_start,
	input  logic [IDX_W-1:0]        xf_addr,
	output logic signed [SMP_W-1:0] samp_rd,
	input  mag_wr_t                 mag_wr,
	input  xf_stat_t                stat,
	output logic                    div_start,
	output logic signed [DIV_W-1:0] div_num,
	output logic signed [DIV_W-1:0] div_den,
	input  logic                    div_done,
	input  logic [Q_W-1:0]          div_quo,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [Q_W-1:0]          normalized_sample,
	output logic [Q_W-1:0]          normalized_magnitude,
	output logic                    bin_present
);

	b_state_t state_q;
	b_state_t state_d;

	logic [IDX_W-1:0]        pos_q;
	logic signed [SMP_W-1:0] floor_q;
	logic signed [SMP_W-1:0] ceil_q;
	logic [ENT_W-1:0]        idx_q;
	logic signed [SMP_W-1:0] samp_rd_q;
	logic [MAG_W-1:0]        mag_rd_q;
	logic signed [DIV_W-1:0] snum_q;
	logic signed [DIV_W-1:0] sden_q;
	logic signed [DIV_W-1:0] mnum_q;
	logic signed [DIV_W-1:0] mden_q;
	logic [Q_W-1:0]          nsamp_q;
	logic [Q_W-1:0]          nmag_q;
	logic                    out_valid_q;

	logic signed [SMP_W-1:0] samp_mem [CHUNK_SIZE];
	logic [MAG_W-1:0]        mag_mem [BIN_COUNT];

	logic             samp_we;
	logic             last_pos;
	logic             out_load;
	logic [IDX_W-1:0] samp_raddr;

	assign last_pos = pos_q == IDX_W'(CHUNK_SIZE - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					if (cmd.opcode == OP_READ) state_d = B_FETCH;
					else if (last_pos) state_d = B_XFORM;
				end
			end
			B_XFORM: if (stat.done) state_d = B_IDLE;
			B_FETCH: state_d = B_SDIV;
			B_SDIV:  state_d = B_SWAIT;
			B_SWAIT: if (div_done) state_d = B_MDIV;
			B_MDIV:  state_d = B_MWAIT;
			B_MWAIT: if (div_done) state_d = B_OUT;
			B_OUT:   if (!out_valid_q || !out_stall) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop        = (state_q == B_IDLE) & cmd_valid;
		samp_we    = pop & (cmd.opcode == OP_LOAD);
		xf_start   = samp_we & last_pos;
		div_start  = (state_q == B_SDIV) | (state_q == B_MDIV);
		div_num    = (state_q == B_MDIV) ? mnum_q : snum_q;
		div_den    = (state_q == B_MDIV) ? mden_q : sden_q;
		out_load   = (state_q == B_OUT) & (~out_valid_q | ~out_stall);
		samp_raddr = (state_q == B_XFORM) ? xf_addr : IDX_W'(cmd.index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			pos_q       <= '0;
			floor_q     <= '0;
			ceil_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (samp_we) pos_q <= last_pos ? '0 : pos_q + IDX_W'(1);
			if (cfg_valid && cfg_index == REG_FLOOR) floor_q <= cfg_data;
			if (cfg_valid && cfg_index == REG_CEIL) ceil_q <= cfg_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (samp_we) samp_mem[pos_q] <= cmd.sample;
		samp_rd_q <= samp_mem[samp_raddr];
		if (mag_wr.we) mag_mem[mag_wr.addr] <= mag_wr.data;
		mag_rd_q <= mag_mem[cmd.index[BIN_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pop) idx_q <= cmd.index;
		if (state_q == B_FETCH) begin
			snum_q <= DIV_W'(samp_rd_q) - DIV_W'(floor_q);
			sden_q <= DIV_W'(ceil_q) - DIV_W'(floor_q);
			mnum_q <= DIV_W'({1'b0, mag_rd_q}) - DIV_W'({1'b0, stat.low});
			mden_q <= DIV_W'({1'b0, stat.high}) - DIV_W'({1'b0, stat.low});
		end
		if (state_q == B_SWAIT && div_done) nsamp_q <= div_quo;
		if (state_q == B_MWAIT && div_done) begin
			nmag_q <= (32'(idx_q) < BIN_COUNT) ? div_quo : '0;
		end
		if (out_load) begin
			normalized_sample    <= (32'(idx_q) < CHUNK_SIZE) ? nsamp_q : '0;
			normalized_magnitude <= nmag_q;
			bin_present          <= 32'(idx_q) < BIN_COUNT;
		end
	end

	assign samp_rd   = samp_rd_q;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/windowed_fft_spectrum_normalizer.sv
`default_nettype none
// Hann-windowed magnitude spectrum with min-max normalization. Load words pass
// through a four-word input queue. The word that completes a chunk starts the
// transform: a direct DFT with one complex multiply-accumulate per cycle; each
// bin goes through accumulation, pipeline drain, rounding, squaring, summing,
// a digit-by-digit square root and the store, BIN_COUNT bins in all; meanwhile
// the queue takes at most four more words and then stalls. A read word runs
// two divisions of up to 16 steps each, one after the other on one shared
// divider. The output register lets the next word enter while a result waits.
module windowed_fft_spectrum_normalizer import wfsn_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    opcode,
	input  logic signed [SMP_W-1:0] sample_value,
	input  logic [ENT_W-1:0]        entry_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [Q_W-1:0]          normalized_sample,
	output logic [Q_W-1:0]          normalized_magnitude,
	output logic                    bin_present,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [SMP_W-1:0]        cfg_data
);

	cmd_t     in_cmd;
	cmd_t     cmd;
	logic     cmd_valid;
	logic     pop;
	logic     xf_start;
	logic [IDX_W-1:0] xf_addr;
	logic signed [SMP_W-1:0] samp_rd;
	mag_wr_t  mag_wr;
	xf_stat_t stat;
	logic     div_start;
	logic signed [DIV_W-1:0] div_num;
	logic signed [DIV_W-1:0] div_den;
	logic     div_done;
	logic [Q_W-1:0] div_quo;

	assign in_cmd.opcode = op_t'(opcode);
	assign in_cmd.sample = sample_value;
	assign in_cmd.index  = entry_index;
	assign cfg_ready     = 1'b1;

	wfsn_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_cmd, .cmd_valid, .cmd, .pop
	);

	wfsn_xform u_xform (
		.clk, .arst_n, .start(xf_start), .samp_addr(xf_addr), .samp_rd, .mag_wr, .stat
	);

	wfsn_div u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	wfsn_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .pop, .cfg_valid, .cfg_index, .cfg_data,
		.xf_start, .xf_addr, .samp_rd, .mag_wr, .stat, .div_start, .div_num,
		.div_den, .div_done, .div_quo, .out_valid, .out_stall, .normalized_sample,
		.normalized_magnitude, .bin_present
	);

endmodule
`default_nettype wire

// File: rtl/wfsn_chk.sv
`default_nettype none
module wfsn_chk import wfsn_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    opcode,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [Q_W-1:0]          normalized_sample,
	input logic [Q_W-1:0]          normalized_magnitude,
	input logic                    bin_present
);

	logic [3:0] pend_q;
	logic       rd_acc;
	logic       out_acc;

	assign rd_acc  = in_valid & ~in_stall & (opcode == OP_READ);
	assign out_acc = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else pend_q <= pend_q + 4'(rd_acc) - 4'(out_acc);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(normalized_sample)
			&& $stable(normalized_magnitude) && $stable(bin_present))
		else $error("result changed while stalled");

	a_no_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bin_present |-> normalized_magnitude == '0)
		else $error("magnitude without bin");

	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result without read");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'(Q_DEPTH + 2))
		else $error("too many reads in flight");

endmodule

bind windowed_fft_spectrum_normalizer wfsn_chk u_chk (.*);
`default_nettype wire
